// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion wrappers, empty under synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`else
`define ASSERT_CLK(label, prop)
`define ASSERT_ALWAYS(label, prop)
`endif
`endif

// ----- rtl/core/qrpt_pkg.sv -----
// ----------------------------------------------------------------------------
// qrpt_pkg
// widths, codes and beat types of the quaternion rigid point transform
// ----------------------------------------------------------------------------
package qrpt_pkg;

  localparam int COORD_WIDTH     = 32;
  localparam int QUAT_FRAC_BITS  = 14;
  localparam int QUAT_WIDTH      = QUAT_FRAC_BITS + 2;
  localparam int COEFF_WIDTH     = QUAT_FRAC_BITS + 4;
  localparam int CMD_WIDTH       = 2;
  localparam int NUM_REGS        = 7;
  localparam int CFG_INDEX_WIDTH = 3;
  localparam int CFG_DATA_WIDTH  = (COORD_WIDTH > QUAT_WIDTH) ? COORD_WIDTH : QUAT_WIDTH;

  localparam logic [CMD_WIDTH-1:0] CMD_POINT     = 2'd0;
  localparam logic [CMD_WIDTH-1:0] CMD_DIR       = 2'd1;
  localparam logic [CMD_WIDTH-1:0] CMD_INV_POINT = 2'd2;
  localparam logic [CMD_WIDTH-1:0] CMD_INV_DIR   = 2'd3;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_QUAT_R = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_QUAT_I = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_QUAT_J = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_QUAT_K = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_POS_X  = 3'd4;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_POS_Y  = 3'd5;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_POS_Z  = 3'd6;

  typedef struct packed {
    logic [CMD_WIDTH-1:0]          command;
    logic signed [COORD_WIDTH-1:0] x_in;
    logic signed [COORD_WIDTH-1:0] y_in;
    logic signed [COORD_WIDTH-1:0] z_in;
  } qrpt_in_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] x_out;
    logic signed [COORD_WIDTH-1:0] y_out;
    logic signed [COORD_WIDTH-1:0] z_out;
    logic                          saturated;
  } qrpt_out_t;

endpackage

// ----- rtl/core/quaternion_rigid_point_transform.sv -----
// ----------------------------------------------------------------------------
// quaternion_rigid_point_transform
// rotates 3d vectors by a quaternion orientation, adding an offset for points; inverse commands undo it
// ----------------------------------------------------------------------------
// channel   dir   handshake              payload
// cfg       in    cfg_write              cfg_index, cfg_data
// in        in    in_valid / in_ready    qrpt_in_t
// out       out   out_valid / out_ready  qrpt_out_t
//
// one beat per cycle sustained while out_ready is high and no matrix rebuild runs
// accept, select/multiply, three-term add and round/clamp stages are registered in turn
// a quaternion write rebuilds the matrix while bld_a and bld_b run, in_ready is low then
// reset loads the identity quaternion and matrix directly, no clearing pass
// out_ready low holds full stages, empty stages still fill behind them
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module quaternion_rigid_point_transform
  import qrpt_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  qrpt_in_t                   in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output qrpt_out_t                  out_data
);

  localparam int QPROD_WIDTH = 2 * QUAT_WIDTH;
  localparam int MSUM_WIDTH  = QPROD_WIDTH + 3;
  localparam int MSH_WIDTH   = MSUM_WIDTH - QUAT_FRAC_BITS;
  localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
  localparam int PROD_WIDTH  = COEFF_WIDTH + DIFF_WIDTH;
  localparam int ACC_WIDTH   = PROD_WIDTH + 2;
  localparam int SH_WIDTH    = ACC_WIDTH - QUAT_FRAC_BITS;

  localparam logic signed [QUAT_WIDTH-1:0]  QUAT_ONE  =
    QUAT_WIDTH'(64'sd1 <<< QUAT_FRAC_BITS);
  localparam logic signed [COEFF_WIDTH-1:0] COEFF_ONE =
    COEFF_WIDTH'(64'sd1 <<< QUAT_FRAC_BITS);
  localparam logic signed [MSUM_WIDTH-1:0]  MSUM_ONE  =
    MSUM_WIDTH'(64'sd1 <<< (2 * QUAT_FRAC_BITS));
  localparam logic signed [MSUM_WIDTH-1:0]  MSUM_HALF =
    MSUM_WIDTH'(64'sd1 <<< (QUAT_FRAC_BITS - 1));
  localparam logic signed [ACC_WIDTH-1:0]   ACC_HALF  =
    ACC_WIDTH'(64'sd1 <<< (QUAT_FRAC_BITS - 1));
  localparam logic signed [MSH_WIDTH-1:0]   MSH_MAX   =
    MSH_WIDTH'((64'sd1 <<< (COEFF_WIDTH - 1)) - 64'sd1);
  localparam logic signed [MSH_WIDTH-1:0]   MSH_MIN   = -MSH_MAX - MSH_WIDTH'(1);
  localparam logic signed [SH_WIDTH-1:0]    SH_MAX    =
    SH_WIDTH'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
  localparam logic signed [SH_WIDTH-1:0]    SH_MIN    = -SH_MAX - SH_WIDTH'(1);
  localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = SH_MAX[COORD_WIDTH-1:0];
  localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = SH_MIN[COORD_WIDTH-1:0];

  function automatic logic signed [COEFF_WIDTH-1:0] coeff_round(
    input logic signed [MSUM_WIDTH-1:0] v
  );
    logic signed [MSUM_WIDTH-1:0] t;
    logic signed [MSH_WIDTH-1:0]  s;
    t = v + MSUM_HALF;
    s = $signed(t[MSUM_WIDTH-1:QUAT_FRAC_BITS]);
    if (s > MSH_MAX) begin
      return MSH_MAX[COEFF_WIDTH-1:0];
    end else if (s < MSH_MIN) begin
      return MSH_MIN[COEFF_WIDTH-1:0];
    end
    return s[COEFF_WIDTH-1:0];
  endfunction

  // configuration registers
  logic signed [QUAT_WIDTH-1:0]  quat [4];
  logic signed [COORD_WIDTH-1:0] pos  [3];
  logic                          bld_a;
  logic                          bld_b;
  logic                          quat_write;

  assign quat_write = cfg_write && (cfg_index == REG_QUAT_R || cfg_index == REG_QUAT_I ||
                                    cfg_index == REG_QUAT_J || cfg_index == REG_QUAT_K);

  always_ff @(posedge clk) begin
    if (rst) begin
      quat[0] <= QUAT_ONE;
      quat[1] <= '0;
      quat[2] <= '0;
      quat[3] <= '0;
      pos[0]  <= '0;
      pos[1]  <= '0;
      pos[2]  <= '0;
      bld_a   <= 1'b0;
      bld_b   <= 1'b0;
    end else begin
      bld_a <= quat_write;
      bld_b <= bld_a;
      if (cfg_write) begin
        unique case (cfg_index)
          REG_QUAT_R: quat[0] <= $signed(cfg_data[QUAT_WIDTH-1:0]);
          REG_QUAT_I: quat[1] <= $signed(cfg_data[QUAT_WIDTH-1:0]);
          REG_QUAT_J: quat[2] <= $signed(cfg_data[QUAT_WIDTH-1:0]);
          REG_QUAT_K: quat[3] <= $signed(cfg_data[QUAT_WIDTH-1:0]);
          REG_POS_X:  pos[0]  <= $signed(cfg_data[COORD_WIDTH-1:0]);
          REG_POS_Y:  pos[1]  <= $signed(cfg_data[COORD_WIDTH-1:0]);
          REG_POS_Z:  pos[2]  <= $signed(cfg_data[COORD_WIDTH-1:0]);
          default: begin
          end
        endcase
      end
    end
  end

  // matrix rebuild: quaternion products, then combine, round and clamp
  logic signed [QPROD_WIDTH-1:0] qp_ii, qp_jj, qp_kk, qp_ij, qp_ik, qp_jk;
  logic signed [QPROD_WIDTH-1:0] qp_ir, qp_jr, qp_kr;

  always_ff @(posedge clk) begin
    qp_ii <= QPROD_WIDTH'(quat[1]) * QPROD_WIDTH'(quat[1]);
    qp_jj <= QPROD_WIDTH'(quat[2]) * QPROD_WIDTH'(quat[2]);
    qp_kk <= QPROD_WIDTH'(quat[3]) * QPROD_WIDTH'(quat[3]);
    qp_ij <= QPROD_WIDTH'(quat[1]) * QPROD_WIDTH'(quat[2]);
    qp_ik <= QPROD_WIDTH'(quat[1]) * QPROD_WIDTH'(quat[3]);
    qp_jk <= QPROD_WIDTH'(quat[2]) * QPROD_WIDTH'(quat[3]);
    qp_ir <= QPROD_WIDTH'(quat[1]) * QPROD_WIDTH'(quat[0]);
    qp_jr <= QPROD_WIDTH'(quat[2]) * QPROD_WIDTH'(quat[0]);
    qp_kr <= QPROD_WIDTH'(quat[3]) * QPROD_WIDTH'(quat[0]);
  end

  logic signed [COEFF_WIDTH-1:0] coef      [9];
  logic signed [COEFF_WIDTH-1:0] coef_next [9];

  always_comb begin
    coef_next[0] = coeff_round(MSUM_ONE -
      ((MSUM_WIDTH'(qp_jj) + MSUM_WIDTH'(qp_kk)) <<< 1));
    coef_next[1] = coeff_round((MSUM_WIDTH'(qp_ij) + MSUM_WIDTH'(qp_kr)) <<< 1);
    coef_next[2] = coeff_round((MSUM_WIDTH'(qp_ik) - MSUM_WIDTH'(qp_jr)) <<< 1);
    coef_next[3] = coeff_round((MSUM_WIDTH'(qp_ij) - MSUM_WIDTH'(qp_kr)) <<< 1);
    coef_next[4] = coeff_round(MSUM_ONE -
      ((MSUM_WIDTH'(qp_ii) + MSUM_WIDTH'(qp_kk)) <<< 1));
    coef_next[5] = coeff_round((MSUM_WIDTH'(qp_jk) + MSUM_WIDTH'(qp_ir)) <<< 1);
    coef_next[6] = coeff_round((MSUM_WIDTH'(qp_ik) + MSUM_WIDTH'(qp_jr)) <<< 1);
    coef_next[7] = coeff_round((MSUM_WIDTH'(qp_jk) - MSUM_WIDTH'(qp_ir)) <<< 1);
    coef_next[8] = coeff_round(MSUM_ONE -
      ((MSUM_WIDTH'(qp_ii) + MSUM_WIDTH'(qp_jj)) <<< 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int n = 0; n < 9; n++) begin
        coef[n] <= (n == 0 || n == 4 || n == 8) ? COEFF_ONE : '0;
      end
    end else if (bld_b) begin
      coef <= coef_next;
    end
  end

  // pipeline control
  logic v1, v2, v3;
  logic en1, en2, en3, en4;
  logic fire;

  assign en4      = !out_valid || out_ready;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1 && !bld_a && !bld_b;
  assign fire     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) begin
        v1 <= fire;
      end
      if (en2) begin
        v2 <= v1;
      end
      if (en3) begin
        v3 <= v2;
      end
      if (en4) begin
        out_valid <= v3;
      end
    end
  end

  // stage 1: accept, offset removal for inverse points
  logic signed [COORD_WIDTH-1:0] vin   [3];
  logic signed [DIFF_WIDTH-1:0]  s1_v  [3];
  logic [CMD_WIDTH-1:0]          s1_cmd;

  assign vin[0] = in_data.x_in;
  assign vin[1] = in_data.y_in;
  assign vin[2] = in_data.z_in;

  always_ff @(posedge clk) begin
    if (fire) begin
      s1_cmd <= in_data.command;
      for (int c = 0; c < 3; c++) begin
        s1_v[c] <= (in_data.command == CMD_INV_POINT) ?
                   DIFF_WIDTH'(vin[c]) - DIFF_WIDTH'(pos[c]) : DIFF_WIDTH'(vin[c]);
      end
    end
  end

  // stage 2: coefficient select and products
  logic signed [PROD_WIDTH-1:0] s2_prod [3][3];
  logic signed [ACC_WIDTH-1:0]  s2_pos  [3];
  logic                         transposed;

  assign transposed = (s1_cmd == CMD_INV_POINT) || (s1_cmd == CMD_INV_DIR);

  always_ff @(posedge clk) begin
    if (en2 && v1) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          s2_prod[r][c] <= PROD_WIDTH'(transposed ? coef[3 * c + r] : coef[3 * r + c]) *
                           PROD_WIDTH'(s1_v[c]);
        end
        s2_pos[r] <= (s1_cmd == CMD_POINT) ? (ACC_WIDTH'(pos[r]) <<< QUAT_FRAC_BITS) : '0;
      end
    end
  end

  // stage 3: row sums with position offset and rounding offset
  logic signed [ACC_WIDTH-1:0] s3_acc [3];

  always_ff @(posedge clk) begin
    if (en3 && v2) begin
      for (int r = 0; r < 3; r++) begin
        s3_acc[r] <= ACC_WIDTH'(s2_prod[r][0]) + ACC_WIDTH'(s2_prod[r][1]) +
                     ACC_WIDTH'(s2_prod[r][2]) + s2_pos[r] + ACC_HALF;
      end
    end
  end

  // stage 4: scale down, saturate, flag
  logic signed [SH_WIDTH-1:0]    sh   [3];
  logic signed [COORD_WIDTH-1:0] res  [3];
  logic [2:0]                    clip;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sh[r] = $signed(s3_acc[r][ACC_WIDTH-1:QUAT_FRAC_BITS]);
      if (sh[r] > SH_MAX) begin
        res[r]  = COORD_MAX;
        clip[r] = 1'b1;
      end else if (sh[r] < SH_MIN) begin
        res[r]  = COORD_MIN;
        clip[r] = 1'b1;
      end else begin
        res[r]  = sh[r][COORD_WIDTH-1:0];
        clip[r] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en4 && v3) begin
      out_data.x_out     <= res[0];
      out_data.y_out     <= res[1];
      out_data.z_out     <= res[2];
      out_data.saturated <= |clip;
    end
  end

  // some output component sits at a rail
  logic out_at_limit;

  assign out_at_limit = out_data.x_out == COORD_MAX || out_data.x_out == COORD_MIN ||
                        out_data.y_out == COORD_MAX || out_data.y_out == COORD_MIN ||
                        out_data.z_out == COORD_MAX || out_data.z_out == COORD_MIN;

  `ASSERT_CLK(a_quat_write_blocks_input, quat_write |=> !in_ready)
  `ASSERT_CLK(a_rebuild_two_cycles, bld_a |=> bld_b)
  `ASSERT_CLK(a_last_stage_moves, v3 && en4 |=> out_valid)
  `ASSERT_CLK(a_flag_means_clipped, out_valid && out_data.saturated |-> out_at_limit)

endmodule
